// ===== hdl/assert_macros.svh =====
// Assertion macros used by the top-level RTL file
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// check prop at every clock edge outside reset
`define ASSERT_CLK(label, clk, rst, prop) \
  label: assert property (@(posedge clk) disable iff (rst) (prop)) \
    else $error("assertion failed");

// check prop at every clock edge, reset included
`define ASSERT_ALWAYS(label, clk, prop) \
  label: assert property (@(posedge clk) (prop)) \
    else $error("assertion failed");

`endif

// ===== hdl/hds8e2_pkg.sv =====
// Package: types and codes of the half-duplex serial 8E2 unit
`default_nettype none
package hds8e2_pkg;

  localparam int RegIdxW = 2;
  localparam int DurW    = 16;

  localparam logic [RegIdxW-1:0] REG_BIT_TICKS  = 2'd0;
  localparam logic [RegIdxW-1:0] REG_RX_OFFSET  = 2'd1;
  localparam logic [RegIdxW-1:0] REG_TX_STOP    = 2'd2;
  localparam logic [RegIdxW-1:0] REG_RX_GUARD   = 2'd3;

  localparam logic [1:0] OP_TICK  = 2'd0;
  localparam logic [1:0] OP_SEND  = 2'd1;
  localparam logic [1:0] OP_RECV  = 2'd2;

  localparam logic [1:0] MODE_IDLE = 2'd0;
  localparam logic [1:0] MODE_TX   = 2'd1;
  localparam logic [1:0] MODE_RX   = 2'd2;

  localparam logic [1:0] TX_START  = 2'd0;
  localparam logic [1:0] TX_DATA   = 2'd1;
  localparam logic [1:0] TX_PARITY = 2'd2;
  localparam logic [1:0] TX_STOP   = 2'd3;

  localparam logic [1:0] RX_WAIT_LOW = 2'd0;
  localparam logic [1:0] RX_OFFSET   = 2'd1;
  localparam logic [1:0] RX_BITS     = 2'd2;
  localparam logic [1:0] RX_GUARD    = 2'd3;

  localparam logic [3:0] BITS_PER_BYTE = 4'd8;

  localparam logic [DurW-1:0] BIT_TICKS_RST = 16'd100;
  localparam logic [DurW-1:0] RX_OFFSET_RST = 16'd30;
  localparam logic [DurW-1:0] TX_STOP_RST   = 16'd200;
  localparam logic [DurW-1:0] RX_GUARD_RST  = 16'd300;

  typedef struct packed {
    logic [DurW-1:0] bit_ticks;
    logic [DurW-1:0] rx_start_offset;
    logic [DurW-1:0] tx_stop_ticks;
    logic [DurW-1:0] rx_guard_ticks;
  } cfg_t;

  typedef struct packed {
    logic       line_out;
    logic       line_drive;
    logic       rx_valid;
    logic [7:0] rx_byte;
    logic       busy_res;
  } res_t;

endpackage
`default_nettype wire

// ===== hdl/hds8e2_regs.sv =====
// Configuration register file with APB-style access
`default_nettype none
module hds8e2_regs
  import hds8e2_pkg::*;
(
  input  wire logic        clk,
  input  wire logic        rst,
  input  wire logic        psel,
  input  wire logic        penable,
  input  wire logic        pwrite,
  input  wire logic [3:0]  paddr,
  input  wire logic [31:0] pwdata,
  output logic      [31:0] prdata,
  output logic             pready,
  output cfg_t             cfg
);

  logic [RegIdxW-1:0] idx;
  logic               wr_en;

  assign idx    = paddr[3:2];
  assign wr_en  = psel && penable && pwrite;
  assign pready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.bit_ticks       <= BIT_TICKS_RST;
      cfg.rx_start_offset <= RX_OFFSET_RST;
      cfg.tx_stop_ticks   <= TX_STOP_RST;
      cfg.rx_guard_ticks  <= RX_GUARD_RST;
    end else if (wr_en) begin
      case (idx)
        REG_BIT_TICKS: cfg.bit_ticks       <= pwdata[DurW-1:0];
        REG_RX_OFFSET: cfg.rx_start_offset <= pwdata[DurW-1:0];
        REG_TX_STOP:   cfg.tx_stop_ticks   <= pwdata[DurW-1:0];
        REG_RX_GUARD:  cfg.rx_guard_ticks  <= pwdata[DurW-1:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    case (idx)
      REG_BIT_TICKS: prdata = {16'd0, cfg.bit_ticks};
      REG_RX_OFFSET: prdata = {16'd0, cfg.rx_start_offset};
      REG_TX_STOP:   prdata = {16'd0, cfg.tx_stop_ticks};
      REG_RX_GUARD:  prdata = {16'd0, cfg.rx_guard_ticks};
      default:       prdata = 32'd0;
    endcase
  end

endmodule
`default_nettype wire

// ===== hdl/hds8e2_engine.sv =====
// Line state machine: advances one tick per accepted word
`default_nettype none
module hds8e2_engine
  import hds8e2_pkg::*;
#(
  parameter int TICK_WIDTH = 16
) (
  input  wire logic       clk,
  input  wire logic       rst,
  input  wire logic       adv,
  input  wire cfg_t       cfg,
  input  wire logic [1:0] op,
  input  wire logic [7:0] tx_byte,
  input  wire logic       line_in,
  output res_t            res
);

  localparam int LimW = (TICK_WIDTH > DurW) ? TICK_WIDTH : DurW;
  localparam logic [TICK_WIDTH-1:0] TickMax = {TICK_WIDTH{1'b1}};

  logic [1:0]            mode, mode_next;
  logic [1:0]            phase, phase_next;
  logic [TICK_WIDTH-1:0] tick_count, tick_count_next;
  logic [3:0]            bit_index, bit_index_next;
  logic [7:0]            shift_reg, shift_reg_next;
  logic                  parity_bit, parity_bit_next;
  logic                  line_level, line_level_next;
  logic                  drive_enable, drive_enable_next;

  logic [DurW-1:0]       dur;
  logic [LimW-1:0]       lim;
  logic [TICK_WIDTH-1:0] tick_inc;
  logic                  hit;
  logic [7:0]            rx_shift;
  logic [3:0]            bit_inc;
  logic                  valid;
  logic [7:0]            rxb;

  always_comb begin
    dur = cfg.bit_ticks;
    if (mode == MODE_TX) begin
      if (phase == TX_STOP) dur = cfg.tx_stop_ticks;
    end else begin
      case (phase)
        RX_OFFSET: dur = cfg.rx_start_offset;
        RX_GUARD:  dur = cfg.rx_guard_ticks;
        default:   dur = cfg.bit_ticks;
      endcase
    end
  end

  assign lim      = (LimW'(dur) > LimW'(TickMax)) ? LimW'(TickMax) : LimW'(dur);
  assign tick_inc = (tick_count == TickMax) ? tick_count : tick_count + 1'b1;
  assign hit      = LimW'(tick_inc) >= lim;
  assign rx_shift = {line_in, shift_reg[7:1]};
  assign bit_inc  = bit_index + 1'b1;

  always_comb begin
    mode_next         = mode;
    phase_next        = phase;
    tick_count_next   = tick_count;
    bit_index_next    = bit_index;
    shift_reg_next    = shift_reg;
    parity_bit_next   = parity_bit;
    line_level_next   = line_level;
    drive_enable_next = drive_enable;
    valid             = 1'b0;
    rxb               = 8'd0;
    case (mode)
      MODE_IDLE: begin
        if (op == OP_SEND) begin
          parity_bit_next   = ^tx_byte;
          shift_reg_next    = tx_byte;
          mode_next         = MODE_TX;
          phase_next        = TX_START;
          tick_count_next   = '0;
          bit_index_next    = 4'd0;
          line_level_next   = 1'b0;
          drive_enable_next = 1'b1;
        end else if (op == OP_RECV) begin
          mode_next         = MODE_RX;
          phase_next        = RX_WAIT_LOW;
          tick_count_next   = '0;
          bit_index_next    = 4'd0;
          shift_reg_next    = 8'd0;
          line_level_next   = 1'b1;
          drive_enable_next = 1'b0;
        end
      end
      MODE_TX: begin
        tick_count_next = tick_inc;
        if (hit) begin
          tick_count_next = '0;
          if (phase == TX_START || (phase == TX_DATA && bit_index < BITS_PER_BYTE)) begin
            phase_next      = TX_DATA;
            line_level_next = shift_reg[0];
            shift_reg_next  = {1'b0, shift_reg[7:1]};
            bit_index_next  = bit_inc;
          end else if (phase == TX_DATA) begin
            phase_next      = TX_PARITY;
            line_level_next = parity_bit;
          end else if (phase == TX_PARITY) begin
            phase_next      = TX_STOP;
            line_level_next = 1'b1;
          end else begin
            mode_next         = MODE_IDLE;
            phase_next        = 2'd0;
            bit_index_next    = 4'd0;
            line_level_next   = 1'b1;
            drive_enable_next = 1'b1;
          end
        end
      end
      default: begin
        case (phase)
          RX_WAIT_LOW: begin
            if (!line_in) begin
              tick_count_next = '0;
              phase_next = (cfg.rx_start_offset == '0) ? RX_BITS : RX_OFFSET;
            end
          end
          RX_OFFSET: begin
            tick_count_next = tick_inc;
            if (hit) begin
              tick_count_next = '0;
              phase_next      = RX_BITS;
            end
          end
          RX_BITS: begin
            tick_count_next = tick_inc;
            if (hit) begin
              tick_count_next = '0;
              shift_reg_next  = rx_shift;
              bit_index_next  = bit_inc;
              if (bit_inc >= BITS_PER_BYTE) begin
                valid          = 1'b1;
                rxb            = rx_shift;
                bit_index_next = 4'd0;
                phase_next     = RX_GUARD;
                if (cfg.rx_guard_ticks == '0) begin
                  mode_next         = MODE_IDLE;
                  phase_next        = 2'd0;
                  line_level_next   = 1'b1;
                  drive_enable_next = 1'b1;
                end
              end
            end
          end
          default: begin
            tick_count_next = tick_inc;
            if (hit) begin
              mode_next         = MODE_IDLE;
              phase_next        = 2'd0;
              tick_count_next   = '0;
              bit_index_next    = 4'd0;
              line_level_next   = 1'b1;
              drive_enable_next = 1'b1;
            end
          end
        endcase
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      mode         <= MODE_IDLE;
      phase        <= 2'd0;
      tick_count   <= '0;
      bit_index    <= 4'd0;
      shift_reg    <= 8'd0;
      parity_bit   <= 1'b0;
      line_level   <= 1'b1;
      drive_enable <= 1'b1;
    end else if (adv) begin
      mode         <= mode_next;
      phase        <= phase_next;
      tick_count   <= tick_count_next;
      bit_index    <= bit_index_next;
      shift_reg    <= shift_reg_next;
      parity_bit   <= parity_bit_next;
      line_level   <= line_level_next;
      drive_enable <= drive_enable_next;
    end
  end

  assign res.line_out   = line_level_next;
  assign res.line_drive = drive_enable_next;
  assign res.rx_valid   = valid;
  assign res.rx_byte    = rxb;
  assign res.busy_res   = (mode_next != MODE_IDLE);

endmodule
`default_nettype wire

// ===== hdl/half_duplex_serial_8e2_unit.sv =====
// Half-duplex single-wire serial 8E2 transceiver, top level
//
// Each input word is one tick of the line: op (0 tick, 1 send tx_byte,
// 2 arm receive; taken only when idle), tx_byte and the sampled line_in.
// Each accepted word yields exactly one output word showing the state
// after that tick: line_out, line_drive, rx_valid, rx_byte, busy_res.
// Words are accepted when in_valid is high and in_stall low; results are
// taken when out_valid is high and out_stall low.
// out_valid rises in the cycle after acceptance; throughput is one word per
// cycle while the receiver does not stall, set by the single state update per
// tick feeding the output register.
// in_stall is high only while a result waits in the output register and
// the receiver stalls it; the engine holds its state meanwhile.
// Timing registers (bit_ticks, rx_start_offset, tx_stop_ticks,
// rx_guard_ticks) sit at byte addresses 0, 4, 8, 12 of the APB-style port.
// Reset is synchronous: the engine's line state goes idle high and driven, the timing
// registers take their defaults and the output register empties.
`default_nettype none
`include "assert_macros.svh"
module half_duplex_serial_8e2_unit
  import hds8e2_pkg::*;
#(
  parameter int TICK_WIDTH = 16
) (
  input  wire logic        clk,
  input  wire logic        rst,
  input  wire logic        in_valid,
  output logic             in_stall,
  input  wire logic [1:0]  op,
  input  wire logic [7:0]  tx_byte,
  input  wire logic        line_in,
  output logic             out_valid,
  input  wire logic        out_stall,
  output logic             line_out,
  output logic             line_drive,
  output logic             rx_valid,
  output logic      [7:0]  rx_byte,
  output logic             busy_res,
  input  wire logic        psel,
  input  wire logic        penable,
  input  wire logic        pwrite,
  input  wire logic [3:0]  paddr,
  input  wire logic [31:0] pwdata,
  output logic      [31:0] prdata,
  output logic             pready
);

  cfg_t cfg;
  res_t res;
  logic adv;

  assign in_stall = out_valid && out_stall;
  assign adv      = in_valid && !in_stall;

  hds8e2_regs u_regs (
    .clk     (clk),
    .rst     (rst),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready),
    .cfg     (cfg)
  );

  hds8e2_engine #(
    .TICK_WIDTH (TICK_WIDTH)
  ) u_engine (
    .clk     (clk),
    .rst     (rst),
    .adv     (adv),
    .cfg     (cfg),
    .op      (op),
    .tx_byte (tx_byte),
    .line_in (line_in),
    .res     (res)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (adv) begin
      out_valid <= 1'b1;
    end else if (!out_stall) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      line_out   <= res.line_out;
      line_drive <= res.line_drive;
      rx_valid   <= res.rx_valid;
      rx_byte    <= res.rx_byte;
      busy_res   <= res.busy_res;
    end
  end

  `ASSERT_CLK(a_idle_line_high, clk, rst, (out_valid && !busy_res) |-> (line_out && line_drive))
  `ASSERT_CLK(a_rx_byte_zero, clk, rst, (out_valid && !rx_valid) |-> (rx_byte == 8'd0))
  `ASSERT_CLK(a_release_high, clk, rst, (out_valid && !line_drive) |-> (line_out && busy_res))
  `ASSERT_ALWAYS(a_no_stall_empty, clk, (!out_valid) |-> (!in_stall))

endmodule
`default_nettype wire
